[rtl/csvtok_pkg.sv]
package csvtok_pkg;

  // Design limits
  localparam int MAX_COLUMNS   = 256;
  localparam int MAX_ROW_BYTES = 65536;

  // Effective caps
  localparam int COL_CAP    = (MAX_COLUMNS > 256) ? 256 : ((MAX_COLUMNS < 1) ? 1 : MAX_COLUMNS);
  localparam int OFFSET_MAX = ((MAX_ROW_BYTES - 1) > 65535) ? 65535 : (MAX_ROW_BYTES - 1);

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int COL_W    = 8;
  localparam int NUMCOL_W = 9;
  localparam int OFS_W    = 16;

  // APB
  localparam int ADDR_W = 2;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-1:0] ADDR_NUM_COLUMNS = 2'd0;

  // Special characters
  localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h22;
  localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

  localparam logic [NUMCOL_W-1:0] COL_CAP_V    = NUMCOL_W'(COL_CAP);
  localparam logic [OFS_W-1:0]    OFFSET_MAX_V = OFS_W'(OFFSET_MAX);

  typedef struct packed {
    logic [BYTE_W-1:0] byte_v;
    logic [COL_W-1:0]  column;
    logic [OFS_W-1:0]  offset;
    logic              field_start;
    logic              is_term;
    logic              row_end;
    logic              in_quotes;
    logic              error;
  } res_t;

  typedef struct packed {
    logic halted;
  } core_status_t;

endpackage

[rtl/csv_field_row_tokenizer.sv]
// Output: an accepted request's result is registered straight into the result register
// when that register is free; otherwise it waits in the skid entry.
// Throughput: one byte per cycle; in_ready drops only when both the result
// register and the skid entry hold undelivered results.
// Reset: synchronous, active-low rst_n; parser returns to the start of a row,
// clears the halt flag and sets num_columns to 1. No clearing pass.
module csv_field_row_tokenizer
  import csvtok_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // APB configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  // byte stream in
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BYTE_W-1:0]   in_byte_in,
  // tokens out
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BYTE_W-1:0]   out_byte_out,
  output logic [COL_W-1:0]    out_column_index,
  output logic [OFS_W-1:0]    out_row_offset,
  output logic                out_field_start,
  output logic                out_is_terminator,
  output logic                out_row_end,
  output logic                out_in_quotes,
  output logic                out_error
);

  logic [NUMCOL_W-1:0] num_columns;
  logic                accept;
  res_t                core_res;
  res_t                out_res;
  core_status_t        status;

  // Single register holding num_columns; the user must write it only while idle, which the block does not enforce.
  csvtok_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .num_columns (num_columns)
  );

  assign accept = in_valid & in_ready;

  // Parser state and per-byte classification, one pass per request.
  csvtok_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .byte_in     (in_byte_in),
    .num_columns (num_columns),
    .res         (core_res),
    .status      (status)
  );

  // Result register plus one skid entry, so in_ready does not depend on out_ready.
  csvtok_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_res  (core_res),
    .ready     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_byte_out      = out_res.byte_v;
  assign out_column_index  = out_res.column;
  assign out_row_offset    = out_res.offset;
  assign out_field_start   = out_res.field_start;
  assign out_is_terminator = out_res.is_term;
  assign out_row_end       = out_res.row_end;
  assign out_in_quotes     = out_res.in_quotes;
  assign out_error         = out_res.error;

  // Halt is sticky until reset.
  a_halt_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    status.halted |=> status.halted)
    else $error("halt flag cleared without reset");

  // Row end only on a terminator.
  a_row_end_term : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_row_end) |-> out_is_terminator)
    else $error("row end without terminator");

  // Error results carry no token flags.
  a_err_flags : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> !(out_is_terminator || out_in_quotes || out_field_start))
    else $error("token flags set on error result");

  // Backpressure only when results are pending.
  a_ready_bp : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

[rtl/csvtok_cfg.sv]
module csvtok_cfg
  import csvtok_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  output logic [NUMCOL_W-1:0] num_columns
);

  logic [NUMCOL_W-1:0] num_columns_r;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr == ADDR_NUM_COLUMNS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_columns_r <= NUMCOL_W'(1);
    end else if (wr_en) begin
      num_columns_r <= pwdata[NUMCOL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_NUM_COLUMNS) begin
      prdata = DATA_W'(num_columns_r);
    end
  end

  assign num_columns = num_columns_r;

endmodule

[rtl/csvtok_core.sv]
module csvtok_core
  import csvtok_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [BYTE_W-1:0]   byte_in,
  input  logic [NUMCOL_W-1:0] num_columns,
  output res_t                res,
  output core_status_t        status
);

  logic              quoted_r, quoted_nxt;
  logic              pend_r, pend_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              afb_r, afb_nxt;
  logic [OFS_W-1:0]  ofs_r, ofs_nxt;
  logic              halted_r, halted_nxt;

  logic [NUMCOL_W-1:0] limit;
  logic [NUMCOL_W-1:0] next_col;
  logic [OFS_W-1:0]    ofs_inc;
  logic                unq, is_q, is_sep;

  // clamp column count to 1..cap
  always_comb begin
    if (num_columns == '0) begin
      limit = NUMCOL_W'(1);
    end else if (num_columns > COL_CAP_V) begin
      limit = COL_CAP_V;
    end else begin
      limit = num_columns;
    end
  end

  assign next_col = {1'b0, col_r} + NUMCOL_W'(1);
  assign ofs_inc  = (ofs_r < OFFSET_MAX_V) ? (ofs_r + OFS_W'(1)) : ofs_r;
  assign is_q     = (byte_in == CH_QUOTE);
  assign is_sep   = (byte_in == CH_COMMA) || (byte_in == CH_NEWLINE);

  always_comb begin
    quoted_nxt      = quoted_r;
    pend_nxt        = pend_r;
    col_nxt         = col_r;
    afb_nxt         = afb_r;
    ofs_nxt         = ofs_r;
    halted_nxt      = halted_r;
    unq             = 1'b0;
    res.byte_v      = byte_in;
    res.column      = col_r;
    res.offset      = ofs_r;
    res.field_start = 1'b0;
    res.is_term     = 1'b0;
    res.row_end     = 1'b0;
    res.in_quotes   = 1'b0;
    res.error       = 1'b0;

    if (halted_r) begin
      res.error = 1'b1;
    end else begin
      res.field_start = afb_r;
      if (pend_r) begin
        pend_nxt = 1'b0;
        if (is_q) begin
          res.in_quotes = 1'b1;        // escaped quote
        end else begin
          quoted_nxt = 1'b0;           // closing quote seen
          unq        = 1'b1;
        end
      end else if (quoted_r) begin
        res.in_quotes = 1'b1;
        if (is_q) begin
          pend_nxt = 1'b1;
        end
      end else begin
        unq = 1'b1;
      end

      if (unq) begin
        if (is_sep) begin
          res.is_term = 1'b1;
        end else if (is_q) begin
          if (afb_r) begin
            quoted_nxt = 1'b1;
          end else begin
            res.error = 1'b1;
          end
        end
      end

      if (res.error) begin
        halted_nxt = 1'b1;
      end else if (res.is_term) begin
        if (next_col >= limit) begin
          res.row_end = 1'b1;
          col_nxt     = '0;
          ofs_nxt     = '0;
        end else begin
          col_nxt = next_col[COL_W-1:0];
          ofs_nxt = ofs_inc;
        end
        afb_nxt = 1'b1;
      end else begin
        afb_nxt = 1'b0;
        ofs_nxt = ofs_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quoted_r <= 1'b0;
      pend_r   <= 1'b0;
      col_r    <= '0;
      afb_r    <= 1'b1;
      ofs_r    <= '0;
      halted_r <= 1'b0;
    end else if (accept) begin
      quoted_r <= quoted_nxt;
      pend_r   <= pend_nxt;
      col_r    <= col_nxt;
      afb_r    <= afb_nxt;
      ofs_r    <= ofs_nxt;
      halted_r <= halted_nxt;
    end
  end

  assign status.halted = halted_r;

endmodule

[rtl/csvtok_obuf.sv]
module csvtok_obuf
  import csvtok_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_res,
  output logic ready,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  res_t main_r;
  res_t skid_r;
  logic main_vld_r;
  logic skid_vld_r;
  logic main_free;

  assign ready     = ~skid_vld_r;
  assign main_free = ~main_vld_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (main_free) begin
      if (skid_vld_r) begin
        main_vld_r <= 1'b1;
        skid_vld_r <= 1'b0;   // no push while skid is full
      end else begin
        main_vld_r <= push;
      end
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_r <= skid_vld_r ? skid_r : push_res;
    end
    if (!main_free && push) begin
      skid_r <= push_res;
    end
  end

  assign out_valid = main_vld_r;
  assign out_res   = main_r;

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import csvtok_pkg::*;

  // Cycles with no request and no token moving before the run is called hung.
  localparam int QUIET_LIMIT = 2000;

  // Per-byte token predictor plus the queue of tokens still owed by the block.
  class csv_token_tracker;
    res_t                expected_tokens[$];
    int unsigned         mismatches;
    logic [NUMCOL_W-1:0] col_setting;
    logic                quoted;       // inside a quoted field
    logic                quote_seen;   // quote read in quoted field, next byte decides
    logic                field_fresh;  // next byte opens a field
    logic                stuck;        // sticky halt after a stray quote
    logic [COL_W-1:0]    column;
    logic [OFS_W-1:0]    offset;

    function new();
      col_setting = NUMCOL_W'(1);
      quoted      = 1'b0;
      quote_seen  = 1'b0;
      field_fresh = 1'b1;
      stuck       = 1'b0;
      column      = '0;
      offset      = '0;
      mismatches  = 0;
    endfunction

    function void set_columns(logic [NUMCOL_W-1:0] value);
      col_setting = value;
    endfunction

    // Fields per row after clamping to 1..COL_CAP.
    function int field_count();
      int n;
      n = int'(col_setting);
      if (n < 1) n = 1;
      if (n > COL_CAP) n = COL_CAP;
      return n;
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      res_t t;
      logic plain;
      logic fault;
      t        = '0;
      t.byte_v = b;
      t.column = column;
      t.offset = offset;
      plain    = 1'b0;
      fault    = 1'b0;
      if (stuck) begin
        t.error = 1'b1;
      end else begin
        t.field_start = field_fresh;
        if (quote_seen) begin
          quote_seen = 1'b0;
          if (b == CH_QUOTE) begin
            t.in_quotes = 1'b1;
          end else begin
            quoted = 1'b0;
            plain  = 1'b1;
          end
        end else if (quoted) begin
          t.in_quotes = 1'b1;
          if (b == CH_QUOTE) quote_seen = 1'b1;
        end else begin
          plain = 1'b1;
        end
        if (plain) begin
          if (b == CH_COMMA || b == CH_NEWLINE) begin
            t.is_term = 1'b1;
          end else if (b == CH_QUOTE) begin
            if (field_fresh) quoted = 1'b1;
            else fault = 1'b1;
          end
        end
        if (fault) begin
          stuck   = 1'b1;
          t.error = 1'b1;
        end else if (t.is_term) begin
          if (int'(column) + 1 >= field_count()) begin
            t.row_end = 1'b1;
            column    = '0;
            offset    = '0;
          end else begin
            column = column + 1'b1;
            if (offset < OFFSET_MAX_V) offset = offset + 1'b1;
          end
          field_fresh = 1'b1;
        end else begin
          field_fresh = 1'b0;
          if (offset < OFFSET_MAX_V) offset = offset + 1'b1;
        end
      end
      expected_tokens.push_back(t);
    endfunction

    function void compare_field(string label, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
      end
    endfunction

    function void check_token(res_t got);
      res_t want;
      if (expected_tokens.size() == 0) begin
        mismatches++;
        $display("%0t: token with no request pending, byte_out %02h", $time, got.byte_v);
        return;
      end
      want = expected_tokens.pop_front();
      compare_field("byte_out",      16'(want.byte_v),      16'(got.byte_v));
      compare_field("column_index",  16'(want.column),      16'(got.column));
      compare_field("row_offset",    want.offset,           got.offset);
      compare_field("field_start",   16'(want.field_start), 16'(got.field_start));
      compare_field("is_terminator", 16'(want.is_term),     16'(got.is_term));
      compare_field("row_end",       16'(want.row_end),     16'(got.row_end));
      compare_field("in_quotes",     16'(want.in_quotes),   16'(got.in_quotes));
      compare_field("error",         16'(want.error),       16'(got.error));
    endfunction
  endclass

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              psel       = 1'b0;
  logic              penable    = 1'b0;
  logic              pwrite     = 1'b0;
  logic [ADDR_W-1:0] paddr      = '0;
  logic [DATA_W-1:0] pwdata     = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_byte_in = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [BYTE_W-1:0] out_byte_out;
  logic [COL_W-1:0]  out_column_index;
  logic [OFS_W-1:0]  out_row_offset;
  logic              out_field_start;
  logic              out_is_terminator;
  logic              out_row_end;
  logic              out_in_quotes;
  logic              out_error;

  csv_field_row_tokenizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte_out     (out_byte_out),
    .out_column_index (out_column_index),
    .out_row_offset   (out_row_offset),
    .out_field_start  (out_field_start),
    .out_is_terminator(out_is_terminator),
    .out_row_end      (out_row_end),
    .out_in_quotes    (out_in_quotes),
    .out_error        (out_error)
  );

  csv_token_tracker tracker;
  int               send_gap_pct   = 0;  // chance per cycle that the sender holds off
  int               recv_stall_pct = 0;  // chance per cycle that out_ready is low
  int unsigned      bytes_sent     = 0;
  int unsigned      quiet_cycles   = 0;
  res_t             seen_token;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: out_ready re-rolled every cycle, independent of out_valid.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: everything sampled at the edge, before this edge's updates land.
  // The token check runs ahead of noting the request, so a token can never
  // be matched against a request taken at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen_token = {out_byte_out, out_column_index, out_row_offset, out_field_start,
                      out_is_terminator, out_row_end, out_in_quotes, out_error};
        tracker.check_token(seen_token);
      end
      if (in_valid && in_ready) tracker.note_byte(in_byte_in);
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: fires only if traffic stops moving altogether.
  initial begin
    @(posedge clk);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // One request: optional random hold-off with valid low, then valid held
  // with a stable byte until the edge that takes it. Valid is left high on
  // return so back-to-back requests never drop it.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Any byte that is neither a quote nor a terminator.
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(255));
    while (b == CH_QUOTE || b == CH_COMMA || b == CH_NEWLINE);
    return b;
  endfunction

  // Inside quotes, terminators are plain data; lean on them a bit.
  function automatic logic [BYTE_W-1:0] quoted_body_byte();
    int roll;
    roll = $urandom_range(19);
    if (roll == 0) return CH_COMMA;
    if (roll == 1) return CH_NEWLINE;
    return plain_byte();
  endfunction

  // One field body, no terminator. Quotes only where they stay legal:
  // opening, doubled inside, closing. Sometimes junk follows the closing
  // quote, which the block takes as unquoted mid-field data.
  task automatic send_field(input int max_len);
    int len;
    if ($urandom_range(99) < 30) begin
      send_byte(CH_QUOTE);
      len = $urandom_range(max_len);
      repeat (len) begin
        if ($urandom_range(7) == 0) begin
          send_byte(CH_QUOTE);
          send_byte(CH_QUOTE);
        end else begin
          send_byte(quoted_body_byte());
        end
      end
      send_byte(CH_QUOTE);
      if ($urandom_range(9) == 0) repeat ($urandom_range(2, 1)) send_byte(plain_byte());
    end else begin
      len = $urandom_range(max_len);
      repeat (len) send_byte(plain_byte());
    end
  endtask

  // Mostly a well-formed row of the configured width; now and then a short
  // or long row, or a swapped comma/newline, to shift the row boundaries.
  task automatic send_row();
    int cols;
    int fields;
    cols   = tracker.field_count();
    fields = cols;
    if ($urandom_range(9) == 0) fields = $urandom_range(cols + 1, 1);
    for (int i = 0; i < fields; i++) begin
      // wide rows: mostly empty fields to keep them short
      if (cols <= 16 || $urandom_range(3) == 0) send_field((cols > 16) ? 1 : 6);
      if ((i == fields - 1) ^ ($urandom_range(9) == 0)) send_byte(CH_NEWLINE);
      else send_byte(CH_COMMA);
    end
  endtask

  // Register write, only with the block drained. Upper data bits are junk
  // on purpose; only the low nine bits are kept.
  task automatic set_column_count(input logic [NUMCOL_W-1:0] value);
    logic [DATA_W-1:0] word;
    in_valid <= 1'b0;
    while (tracker.expected_tokens.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    word = $urandom;
    word[NUMCOL_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_NUM_COLUMNS;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);  // access edge: register written here
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_columns(value);
  endtask

  initial begin
    logic [NUMCOL_W-1:0] width_pick;
    int unsigned         stop_at;
    tracker = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles 21%, receiver stalls 50%.
    send_gap_pct   = 21;
    recv_stall_pct = 50;

    // Directed, reset width of one column: every terminator closes the row,
    // and a bare comma is an empty field.
    send_text("a\n,");
    set_column_count(3);
    // Escaped quote, empty quoted field, quoted comma, junk after a closing
    // quote, then the byte extremes and an empty trailing field.
    send_text("\"x\"\"y\",\"\",\"a,b\"c\n");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text(",\n\n");

    // Random rows over three idle profiles, three widths each. Widths cover
    // zero (acts as one), one, the cap and above the cap.
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_gap_pct   = 50;
        recv_stall_pct = 21;
      end else if (phase == 2) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      for (int k = 0; k < 3; k++) begin
        case (phase * 3 + k)
          0: width_pick = NUMCOL_W'(2);
          1: width_pick = NUMCOL_W'(0);
          2: width_pick = NUMCOL_W'(3);
          3: width_pick = NUMCOL_W'(256);
          4: width_pick = NUMCOL_W'(1);
          5: width_pick = NUMCOL_W'($urandom_range(12, 4));
          6: width_pick = NUMCOL_W'(511);
          7: width_pick = NUMCOL_W'(5);
          default: width_pick = NUMCOL_W'($urandom_range(12, 0));
        endcase
        set_column_count(width_pick);
        stop_at = bytes_sent + 32;
        while (bytes_sent < stop_at) send_row();
      end
    end

    // Two-column width, then two fields closed by a comma and a newline.
    set_column_count(2);
    send_byte(plain_byte());
    send_byte(CH_COMMA);
    send_byte(plain_byte());
    send_byte(CH_NEWLINE);

    // Stray quote mid-field: error and halt. Everything after stays flagged
    // and leaves the counters alone, quotes and terminators included.
    send_text("a\"");
    send_text("\",\nq");
    send_byte(8'hFF);

    in_valid <= 1'b0;
    while (tracker.expected_tokens.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.expected_tokens.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[csv_field_row_tokenizer.f]
rtl/csvtok_pkg.sv
rtl/csvtok_cfg.sv
rtl/csvtok_core.sv
rtl/csvtok_obuf.sv
rtl/csv_field_row_tokenizer.sv
tb/testbench.sv
